// ----- hdl/c2pa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package c2pa_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int ANGLE_STEPS_DEF = 16;

  // coordinates are scaled up before the rotations so that the shifts keep every bit
  localparam int SCALE_SHIFT = 24;
  // angle accumulator, 1/2^20 degree
  localparam int Z_W   = 30;
  localparam int ZFRAC = 20;
  localparam int TABLE_LEN = 24;

  localparam int ANGLE_W  = 17;
  localparam int ANGLE_FRAC = 7;
  localparam int ANGLE_MIN  = -11520;
  localparam int ANGLE_MAX  = 34560;
  localparam int ANGLE_UP   = 11520;
  localparam int ANGLE_HALF = 23040;

  localparam int CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_X = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_Y = 8'd1;

  typedef struct packed {
    logic dx_zero;
    logic dy_zero;
    logic dy_neg;
    logic dx_neg;
  } c2pa_flags_t;

  // atan(2^-i) in degrees, scaled by 2^20
  function automatic logic signed [Z_W-1:0] atan_entry(input int step);
    logic signed [Z_W-1:0] a;
    case (step)
      0:  a = 30'sd47185920;
      1:  a = 30'sd27855475;
      2:  a = 30'sd14718068;
      3:  a = 30'sd7471121;
      4:  a = 30'sd3750058;
      5:  a = 30'sd1876857;
      6:  a = 30'sd938658;
      7:  a = 30'sd469357;
      8:  a = 30'sd234682;
      9:  a = 30'sd117342;
      10: a = 30'sd58671;
      11: a = 30'sd29335;
      12: a = 30'sd14668;
      13: a = 30'sd7334;
      14: a = 30'sd3667;
      15: a = 30'sd1833;
      16: a = 30'sd917;
      17: a = 30'sd458;
      18: a = 30'sd229;
      19: a = 30'sd115;
      20: a = 30'sd57;
      21: a = 30'sd29;
      22: a = 30'sd14;
      23: a = 30'sd7;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/c2pa_point_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface c2pa_point_if import c2pa_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

`default_nettype wire

// ----- hdl/c2pa_angle_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface c2pa_angle_if import c2pa_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] angle_degrees;

  modport source (output valid, output angle_degrees, input ready);
  modport sink   (input valid, input angle_degrees, output ready);
endinterface

`default_nettype wire

// ----- hdl/c2pa_cfg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface c2pa_cfg_if import c2pa_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [COORD_WIDTH-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/cartesian_to_polar_angle_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// An accepted point passes through the offset, fold, rotation, bias and output stages to its angle beat.
// Throughput: one point per cycle while the output is not stalled; each rotation step has a register stage of its own.
// A stalled output fills empty stages first, then holds the pipeline back to the input.
// Reset (synchronous, rst_n low) clears every stage valid and sets both centres to zero.
// Configuration writes are always taken; an index beyond the two centres is dropped.
module cartesian_to_polar_angle_top import c2pa_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int ANGLE_STEPS = ANGLE_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  c2pa_point_if.sink   in_pt,
  c2pa_angle_if.source out_ang,
  c2pa_cfg_if.sink     cfg_wr
);

  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int XY_W   = COORD_WIDTH + SCALE_SHIFT + 4;
  localparam logic signed [Z_W-1:0] HALF_TURN_Z = Z_W'(180) <<< ZFRAC;
  localparam logic signed [Z_W-1:0] ROUND_BIAS  = Z_W'(1) <<< (ZFRAC - ANGLE_FRAC - 1);

  // configuration registers
  logic signed [COORD_WIDTH-1:0] center_x_r, center_y_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        CFG_CENTER_X: center_x_r <= cfg_wr.data;
        CFG_CENTER_Y: center_y_r <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // stage: offset from the centre
  logic                     d_v_r, d_load, p_load;
  logic signed [DIFF_W-1:0] dx_r, dy_r;

  assign d_load      = !d_v_r || p_load;
  assign in_pt.ready = d_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (d_load) begin
      d_v_r <= in_pt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_load && in_pt.valid) begin
      dx_r <= {in_pt.point_x[COORD_WIDTH-1], in_pt.point_x}
            - {center_x_r[COORD_WIDTH-1], center_x_r};
      dy_r <= {in_pt.point_y[COORD_WIDTH-1], in_pt.point_y}
            - {center_y_r[COORD_WIDTH-1], center_y_r};
    end
  end

  // stage: fold the left half plane over and scale up
  logic                   p_v_r;
  logic signed [XY_W-1:0] p_x_r, p_y_r, dx_ext, dy_ext, x_nxt, y_nxt;
  c2pa_flags_t            p_flags_r, p_flags_nxt;

  logic                   c_v   [0:ANGLE_STEPS];
  logic                   c_rdy [0:ANGLE_STEPS];
  logic signed [XY_W-1:0] c_x   [0:ANGLE_STEPS];
  logic signed [XY_W-1:0] c_y   [0:ANGLE_STEPS];
  logic signed [Z_W-1:0]  c_z   [0:ANGLE_STEPS];
  c2pa_flags_t            c_flags [0:ANGLE_STEPS];

  assign p_load = !p_v_r || c_rdy[0];

  always_comb begin
    dx_ext = {{(XY_W-DIFF_W){dx_r[DIFF_W-1]}}, dx_r};
    dy_ext = {{(XY_W-DIFF_W){dy_r[DIFF_W-1]}}, dy_r};
    p_flags_nxt.dx_zero = (dx_r == '0);
    p_flags_nxt.dy_zero = (dy_r == '0);
    p_flags_nxt.dy_neg  = dy_r[DIFF_W-1];
    p_flags_nxt.dx_neg  = dx_r[DIFF_W-1];
    if (dx_r[DIFF_W-1]) begin
      x_nxt = (-dx_ext) <<< SCALE_SHIFT;
      y_nxt = (-dy_ext) <<< SCALE_SHIFT;
    end else begin
      x_nxt = dx_ext <<< SCALE_SHIFT;
      y_nxt = dy_ext <<< SCALE_SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (p_load) begin
      p_v_r <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p_load && d_v_r) begin
      p_x_r     <= x_nxt;
      p_y_r     <= y_nxt;
      p_flags_r <= p_flags_nxt;
    end
  end

  assign c_v[0]     = p_v_r;
  assign c_x[0]     = p_x_r;
  assign c_y[0]     = p_y_r;
  assign c_z[0]     = '0;
  assign c_flags[0] = p_flags_r;

  // rotation stages, one per step
  for (genvar k = 0; k < ANGLE_STEPS; k++) begin : g_step
    c2pa_cordic_stage #(
      .XY_W (XY_W),
      .STEP (k)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (c_v[k]),
      .in_ready  (c_rdy[k]),
      .x_in      (c_x[k]),
      .y_in      (c_y[k]),
      .z_in      (c_z[k]),
      .flags_in  (c_flags[k]),
      .out_valid (c_v[k+1]),
      .out_ready (c_rdy[k+1]),
      .x_out     (c_x[k+1]),
      .y_out     (c_y[k+1]),
      .z_out     (c_z[k+1]),
      .flags_out (c_flags[k+1])
    );
  end

  // stage: add the half turn for the left half plane, and the rounding bias
  logic                  r_v_r, r_load, out_load;
  logic signed [Z_W-1:0] r_z_r;
  c2pa_flags_t           r_flags_r;

  assign r_load = !r_v_r || out_load;
  assign c_rdy[ANGLE_STEPS] = r_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_v_r <= 1'b0;
    end else if (r_load) begin
      r_v_r <= c_v[ANGLE_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (r_load && c_v[ANGLE_STEPS]) begin
      r_z_r     <= c_z[ANGLE_STEPS] + (c_flags[ANGLE_STEPS].dx_neg ? HALF_TURN_Z : '0)
                 + ROUND_BIAS;
      r_flags_r <= c_flags[ANGLE_STEPS];
    end
  end

  // stage: scale to 1/128 degree, special cases, clamp
  logic                      out_v_r;
  logic signed [ANGLE_W-1:0] out_angle_r, angle_nxt;
  logic signed [Z_W-1:0]     z_scaled;

  assign out_load = !out_v_r || out_ang.ready;

  always_comb begin
    z_scaled = r_z_r >>> (ZFRAC - ANGLE_FRAC);
    if (r_flags_r.dx_zero) begin
      angle_nxt = r_flags_r.dy_neg ? -ANGLE_W'(ANGLE_UP) : ANGLE_W'(ANGLE_UP);
    end else if (r_flags_r.dy_zero) begin
      angle_nxt = r_flags_r.dx_neg ? ANGLE_W'(ANGLE_HALF) : '0;
    end else if (z_scaled < ANGLE_MIN) begin
      angle_nxt = ANGLE_W'(ANGLE_MIN);
    end else if (z_scaled > ANGLE_MAX) begin
      angle_nxt = ANGLE_W'(ANGLE_MAX);
    end else begin
      angle_nxt = z_scaled[ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= r_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && r_v_r) begin
      out_angle_r <= angle_nxt;
    end
  end

  assign out_ang.valid         = out_v_r;
  assign out_ang.angle_degrees = out_angle_r;

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_angle_r >= ANGLE_MIN && out_angle_r <= ANGLE_MAX))
    else $error("angle beat outside the clamped range");

  a_vertical: assert property (@(posedge clk) disable iff (!rst_n)
    (r_v_r && out_load && r_flags_r.dx_zero) |=>
      (out_angle_r == ($past(r_flags_r.dy_neg) ? -ANGLE_W'(ANGLE_UP) : ANGLE_W'(ANGLE_UP))))
    else $error("vertical offset did not give plus or minus 90 degrees");

  a_horizontal: assert property (@(posedge clk) disable iff (!rst_n)
    (r_v_r && out_load && !r_flags_r.dx_zero && r_flags_r.dy_zero) |=>
      (out_angle_r == ($past(r_flags_r.dx_neg) ? ANGLE_W'(ANGLE_HALF) : '0)))
    else $error("horizontal offset did not give 0 or 180 degrees");

  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (in_pt.valid && in_pt.ready) |=> d_v_r)
    else $error("accepted point lost at the first stage");

endmodule

`default_nettype wire

// ----- hdl/c2pa_cordic_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module c2pa_cordic_stage import c2pa_pkg::*; #(
  parameter int XY_W = COORD_WIDTH_DEF + SCALE_SHIFT + 4,
  parameter int STEP = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [XY_W-1:0] x_in,
  input  logic signed [XY_W-1:0] y_in,
  input  logic signed [Z_W-1:0]  z_in,
  input  c2pa_flags_t            flags_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [XY_W-1:0] x_out,
  output logic signed [XY_W-1:0] y_out,
  output logic signed [Z_W-1:0]  z_out,
  output c2pa_flags_t            flags_out
);

  localparam logic signed [Z_W-1:0] STEP_ANGLE = atan_entry(STEP);

  logic                   v_r;
  logic signed [XY_W-1:0] x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic signed [Z_W-1:0]  z_r, z_nxt;
  c2pa_flags_t            flags_r;
  logic                   load;

  // take a beat whenever the slot is empty or drains this cycle
  assign load     = !v_r || out_ready;
  assign in_ready = load;

  always_comb begin
    xs = x_in >>> STEP;
    ys = y_in >>> STEP;
    if (!y_in[XY_W-1]) begin
      x_nxt = x_in + ys;
      y_nxt = y_in - xs;
      z_nxt = z_in + STEP_ANGLE;
    end else begin
      x_nxt = x_in - ys;
      y_nxt = y_in + xs;
      z_nxt = z_in - STEP_ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (load) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      z_r     <= z_nxt;
      flags_r <= flags_in;
    end
  end

  assign out_valid = v_r;
  assign x_out     = x_r;
  assign y_out     = y_r;
  assign z_out     = z_r;
  assign flags_out = flags_r;

endmodule

`default_nettype wire
